// File: rtl/dgec_pkg.sv
// Package: constants and types for the decision graph edge classifier.
`default_nettype none
package dgec_pkg;
  localparam int ATOM_DEPTH = 256;
  localparam int NODE_DEPTH = 256;
  localparam int EDGE_DEPTH = 1024;
  localparam int PROGRAM_DEPTH = 4096;
  localparam int FIELD_DEPTH = 64;
  localparam int STACK_DEPTH = 16;
  localparam int AW = $clog2(ATOM_DEPTH);
  localparam int NW = $clog2(NODE_DEPTH);
  localparam int EW = $clog2(EDGE_DEPTH);
  localparam int PW = $clog2(PROGRAM_DEPTH);
  localparam int FW = $clog2(FIELD_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] CMD_ATOM = 3'd0;
  localparam logic [2:0] CMD_NODE = 3'd1;
  localparam logic [2:0] CMD_EDGE = 3'd2;
  localparam logic [2:0] CMD_PROG = 3'd3;
  localparam logic [2:0] CMD_FIELD = 3'd4;
  localparam logic [2:0] CMD_EVAL = 3'd5;

  localparam logic [15:0] OP_NOT = 16'h8000;
  localparam logic [15:0] OP_AND = 16'h8001;
  localparam logic [15:0] OP_OR = 16'h8002;
  localparam logic [15:0] OP_TRUE = 16'h8003;
  localparam logic [15:0] OP_FALSE = 16'h8004;

  localparam logic [1:0] TY_NONE = 2'd0;
  localparam logic [1:0] TY_BOOL = 2'd1;
  localparam logic [1:0] TY_INT = 2'd2;
  localparam logic [1:0] TY_STR = 2'd3;

  localparam logic [2:0] AOP_EQ = 3'd0;
  localparam logic [2:0] AOP_NE = 3'd1;
  localparam logic [2:0] AOP_LT = 3'd2;
  localparam logic [2:0] AOP_LE = 3'd3;
  localparam logic [2:0] AOP_GT = 3'd4;
  localparam logic [2:0] AOP_GE = 3'd5;
  localparam logic [2:0] AOP_TRUTHY = 3'd6;

  localparam logic [1:0] FLT_OK = 2'd0;
  localparam logic [1:0] FLT_STACK = 2'd1;
  localparam logic [1:0] FLT_ADDR = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [11:0] index;
    logic [7:0] atom_field;
    logic [2:0] atom_op;
    logic [1:0] value_type;
    logic signed [31:0] value;
    logic [11:0] offset;
    logic [12:0] count;
    logic [7:0] target;
    logic [15:0] program_word;
  } req_t;

  typedef struct packed {
    logic matched;
    logic [11:0] hit_edge;
    logic [7:0] next_node;
    logic [1:0] fault;
  } res_t;

  function automatic logic is_num(input logic [1:0] ty);
    return ty == TY_BOOL || ty == TY_INT;
  endfunction

  function automatic logic atom_test(input logic [2:0] op, input logic [1:0] aty,
                                     input logic signed [31:0] aval,
                                     input logic [1:0] fty,
                                     input logic signed [31:0] fval);
    logic num, eq, r;
    num = is_num(aty) && is_num(fty);
    eq = (num && fval == aval) || (aty == TY_STR && fty == TY_STR && fval == aval) ||
         (aty == TY_NONE && fty == TY_NONE);
    case (op)
      AOP_EQ: r = eq;
      AOP_NE: r = !eq;
      AOP_LT: r = num && fval < aval;
      AOP_LE: r = num && fval <= aval;
      AOP_GT: r = num && fval > aval;
      AOP_GE: r = num && fval >= aval;
      AOP_TRUTHY: r = fty != TY_NONE && fval != 0;
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/dgec_if.sv
// Interfaces: request, result and configuration channels.
`default_nettype none
interface dgec_req_if import dgec_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface dgec_res_if import dgec_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface dgec_cfg_if;
  logic valid;
  logic ready;
  logic [6:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/decision_graph_edge_classifier.sv
// Top level: stores, graph walker and postfix evaluator.
//
// channel | dir | payload
// req     | in  | command, index, atom_field, atom_op, value_type, value, offset,
//         |     | count, target, program_word
// res     | out | matched, hit_edge, next_node, fault
// cfg     | in  | field_count
//
// Writes are stored when the request is taken. Evaluate: read the node, then per edge
// read the edge, run its program word by word and close it (an atom word reads the
// program, atom and field memories one after another), then register the result.
// Reset is synchronous and clears control only; the stores are undefined until written.
// No request is taken while an evaluate runs or a result waits.
`default_nettype none
module decision_graph_edge_classifier import dgec_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  dgec_req_if.sink req,
  dgec_res_if.source res,
  dgec_cfg_if.sink cfg
);
  typedef enum logic [3:0] {
    S_IDLE, S_NODE, S_EDGE_CHK, S_EDGE_RD, S_EDGE, S_WORD, S_PWAIT, S_PROG,
    S_AWAIT, S_ATOM, S_FWAIT, S_FIELD, S_ENDEDGE, S_DONE
  } state_t;

  logic [52:0] atom_mem [ATOM_DEPTH];
  logic [24:0] node_mem [NODE_DEPTH];
  logic [32:0] edge_mem [EDGE_DEPTH];
  logic [15:0] prog_mem [PROGRAM_DEPTH];
  logic [33:0] field_mem [FIELD_DEPTH];

  state_t state;
  logic [6:0] field_count;
  logic [52:0] atom_q;
  logic [24:0] node_q;
  logic [32:0] edge_q;
  logic [15:0] prog_q;
  logic [33:0] field_q;
  logic [AW-1:0] atom_ra;
  logic [NW-1:0] node_ra;
  logic [EW-1:0] edge_ra;
  logic [PW-1:0] prog_ra;
  logic [FW-1:0] field_ra;
  logic [12:0] eoff_base, ecnt, ei, poff_base, pcnt, pi;
  logic [7:0] etgt;
  logic [STACK_DEPTH-1:0] stk;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_m1, sp_m2;
  logic field_ok;
  res_t out;
  logic out_valid;

  logic [13:0] ea, pa;
  logic [7:0] a_fld;
  logic abit;

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign cfg.ready = 1'b1;
  assign res.valid = out_valid;
  assign res.data = out;

  assign ea = {1'b0, eoff_base} + {1'b0, ei};
  assign pa = {1'b0, poff_base} + {1'b0, pi};
  assign sp_m1 = sp - 1'b1;
  assign sp_m2 = sp - 2'd2;
  assign a_fld = atom_q[52:45];
  assign abit = atom_test(atom_q[44:42], atom_q[41:40], atom_q[39:8],
                          field_ok ? field_q[33:32] : TY_NONE,
                          field_ok ? field_q[31:0] : 32'sd0);

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      case (req.data.command)
        CMD_ATOM: if (req.data.index < ATOM_DEPTH)
          atom_mem[req.data.index[AW-1:0]] <= {req.data.atom_field, req.data.atom_op,
                                               req.data.value_type, req.data.value,
                                               8'd0};
        CMD_NODE: if (req.data.index < NODE_DEPTH)
          node_mem[req.data.index[NW-1:0]] <= {req.data.offset, req.data.count};
        CMD_EDGE: if (req.data.index < EDGE_DEPTH)
          edge_mem[req.data.index[EW-1:0]] <= {req.data.target, req.data.offset,
                                               req.data.count};
        CMD_PROG: if (req.data.index < PROGRAM_DEPTH)
          prog_mem[req.data.index[PW-1:0]] <= req.data.program_word;
        CMD_FIELD: if (req.data.index < FIELD_DEPTH)
          field_mem[req.data.index[FW-1:0]] <= {req.data.value_type, req.data.value};
        default: ;
      endcase
    end
    atom_q <= atom_mem[atom_ra];
    node_q <= node_mem[node_ra];
    edge_q <= edge_mem[edge_ra];
    prog_q <= prog_mem[prog_ra];
    field_q <= field_mem[field_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      field_count <= 7'd0;
      sp <= '0;
    end else begin
      if (cfg.valid) field_count <= cfg.data;
      if (res.valid && res.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (req.valid && req.ready && req.data.command == CMD_EVAL) begin
          if (req.data.index >= NODE_DEPTH) begin
            out <= '{matched: 1'b0, hit_edge: 12'd0, next_node: 8'd0, fault: FLT_ADDR};
            state <= S_DONE;
          end else begin
            out <= '0;
            node_ra <= req.data.index[NW-1:0];
            state <= S_NODE;
          end
        end
        S_NODE: state <= S_EDGE_CHK;
        S_EDGE_CHK: begin
          eoff_base <= {1'b0, node_q[24:13]};
          ecnt <= node_q[12:0];
          ei <= 13'd0;
          state <= S_EDGE_RD;
        end
        S_EDGE_RD: begin
          if (ei >= ecnt) state <= S_DONE;
          else if (ea >= EDGE_DEPTH) begin
            out.fault <= FLT_ADDR;
            state <= S_DONE;
          end else begin
            edge_ra <= ea[EW-1:0];
            state <= S_EDGE;
          end
        end
        S_EDGE: state <= S_ENDEDGE;
        S_ENDEDGE: begin
          etgt <= edge_q[32:25];
          poff_base <= {1'b0, edge_q[24:13]};
          pcnt <= edge_q[12:0];
          pi <= 13'd0;
          sp <= '0;
          state <= S_WORD;
        end
        S_WORD: begin
          if (pi >= pcnt) begin
            if (sp != 0 && stk[0]) begin
              out.matched <= 1'b1;
              out.hit_edge <= ei[11:0];
              out.next_node <= etgt;
              state <= S_DONE;
            end else begin
              ei <= ei + 13'd1;
              state <= S_EDGE_RD;
            end
          end else if (pa >= PROGRAM_DEPTH) begin
            out.fault <= FLT_ADDR;
            state <= S_DONE;
          end else begin
            prog_ra <= pa[PW-1:0];
            state <= S_PWAIT;
          end
        end
        S_PWAIT: state <= S_PROG;
        S_PROG: begin
          pi <= pi + 13'd1;
          state <= S_WORD;
          if (prog_q < OP_NOT) begin
            if (prog_q >= ATOM_DEPTH) begin
              out.fault <= FLT_ADDR;
              state <= S_DONE;
            end else begin
              atom_ra <= prog_q[AW-1:0];
              state <= S_AWAIT;
            end
          end else if (prog_q == OP_NOT) begin
            if (sp == 0) begin
              out.fault <= FLT_STACK;
              state <= S_DONE;
            end else stk[sp_m1[SPW-2:0]] <= !stk[sp_m1[SPW-2:0]];
          end else if (prog_q == OP_AND || prog_q == OP_OR) begin
            if (sp < 2) begin
              out.fault <= FLT_STACK;
              state <= S_DONE;
            end else begin
              stk[sp_m2[SPW-2:0]] <= (prog_q == OP_AND) ?
                                     (stk[sp_m2[SPW-2:0]] & stk[sp_m1[SPW-2:0]]) :
                                     (stk[sp_m2[SPW-2:0]] | stk[sp_m1[SPW-2:0]]);
              sp <= sp_m1;
            end
          end else if (prog_q == OP_TRUE || prog_q == OP_FALSE) begin
            if (sp >= STACK_DEPTH) begin
              out.fault <= FLT_STACK;
              state <= S_DONE;
            end else begin
              stk[sp[SPW-2:0]] <= (prog_q == OP_TRUE);
              sp <= sp + 1'b1;
            end
          end
        end
        S_AWAIT: state <= S_ATOM;
        S_ATOM: begin
          field_ra <= a_fld[FW-1:0];
          field_ok <= ({1'b0, a_fld} < {1'b0, field_count}) && (a_fld < FIELD_DEPTH);
          state <= S_FWAIT;
        end
        S_FWAIT: state <= S_FIELD;
        S_FIELD: begin
          if (sp >= STACK_DEPTH) begin
            out.fault <= FLT_STACK;
            state <= S_DONE;
          end else begin
            stk[sp[SPW-2:0]] <= abit;
            sp <= sp + 1'b1;
            state <= S_WORD;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sp: assert property (@(posedge clk) disable iff (rst) sp <= STACK_DEPTH)
    else $error("stack pointer beyond depth");
  a_ready: assert property (@(posedge clk) disable iff (rst) out_valid |-> !req.ready)
    else $error("request taken while result pending");
  a_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid)
    else $error("result not raised");
  a_flt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.fault != FLT_OK |-> !out.matched)
    else $error("fault with match");
`endif
endmodule
`default_nettype wire

// File: test/decision_graph_edge_classifier_test.sv
// Testbench: fills the graph stores, runs directed and random requests, checks evaluate results.
`timescale 1ns / 100ps
module decision_graph_edge_classifier_test import dgec_pkg::*; ();

  class classifier_scoreboard;
    req_t atoms[ATOM_DEPTH];
    req_t nodes[NODE_DEPTH];
    req_t edges[EDGE_DEPTH];
    logic [15:0] words[PROGRAM_DEPTH];
    logic [1:0] field_ty[FIELD_DEPTH];
    logic signed [31:0] field_val[FIELD_DEPTH];
    logic [6:0] field_count;
    res_t verdict_q[$];
    bit stk[STACK_DEPTH];
    int sp;
    int errors, evals, hits, faults;

    function new();
      field_count = '0;
    endfunction

    function automatic logic atom_holds(req_t a);
      logic [1:0] fty;
      logic signed [31:0] fval;
      logic both_num, same;
      fty = TY_NONE;
      fval = '0;
      if (a.atom_field < field_count && a.atom_field < FIELD_DEPTH) begin
        fty = field_ty[a.atom_field];
        fval = field_val[a.atom_field];
      end
      both_num = (fty == TY_BOOL || fty == TY_INT) &&
                 (a.value_type == TY_BOOL || a.value_type == TY_INT);
      if (both_num || (fty == TY_STR && a.value_type == TY_STR))
        same = (fval == a.value);
      else
        same = (fty == TY_NONE && a.value_type == TY_NONE);
      case (a.atom_op)
        AOP_EQ: return same;
        AOP_NE: return !same;
        AOP_LT: return both_num && fval < a.value;
        AOP_LE: return both_num && fval <= a.value;
        AOP_GT: return both_num && fval > a.value;
        AOP_GE: return both_num && fval >= a.value;
        AOP_TRUTHY: return fty != TY_NONE && fval != 0;
        default: return 1'b0;
      endcase
    endfunction

    function automatic logic [1:0] push(logic b);
      if (sp >= STACK_DEPTH) return FLT_STACK;
      stk[sp] = b;
      sp++;
      return FLT_OK;
    endfunction

    function automatic logic [1:0] run_edge(req_t e, output logic hit);
      int pa;
      logic [15:0] w;
      logic [1:0] f;
      sp = 0;
      hit = 1'b0;
      for (int j = 0; j < e.count; j++) begin
        pa = e.offset + j;
        if (pa >= PROGRAM_DEPTH) return FLT_ADDR;
        w = words[pa];
        f = FLT_OK;
        if (w < OP_NOT) begin
          if (w >= ATOM_DEPTH) return FLT_ADDR;
          f = push(atom_holds(atoms[w]));
        end else if (w == OP_NOT) begin
          if (sp < 1) return FLT_STACK;
          stk[sp-1] = !stk[sp-1];
        end else if (w == OP_AND || w == OP_OR) begin
          if (sp < 2) return FLT_STACK;
          sp--;
          stk[sp-1] = (w == OP_AND) ? (stk[sp-1] & stk[sp]) : (stk[sp-1] | stk[sp]);
        end else if (w == OP_TRUE) begin
          f = push(1'b1);
        end else if (w == OP_FALSE) begin
          f = push(1'b0);
        end
        if (f != FLT_OK) return f;
      end
      hit = sp > 0 && stk[0];
      return FLT_OK;
    endfunction

    function automatic res_t classify(logic [11:0] node);
      res_t r;
      int ea;
      logic hit;
      r = '0;
      if (node >= NODE_DEPTH) begin
        r.fault = FLT_ADDR;
        return r;
      end
      for (int i = 0; i < nodes[node].count; i++) begin
        ea = nodes[node].offset + i;
        if (ea >= EDGE_DEPTH) begin
          r.fault = FLT_ADDR;
          return r;
        end
        r.fault = run_edge(edges[ea], hit);
        if (r.fault != FLT_OK) return r;
        if (hit) begin
          r.matched = 1'b1;
          r.hit_edge = i[11:0];
          r.next_node = edges[ea].target;
          return r;
        end
      end
      return r;
    endfunction

    function void note(req_t q);
      res_t r;
      case (q.command)
        CMD_ATOM: if (q.index < ATOM_DEPTH) atoms[q.index] = q;
        CMD_NODE: if (q.index < NODE_DEPTH) nodes[q.index] = q;
        CMD_EDGE: if (q.index < EDGE_DEPTH) edges[q.index] = q;
        CMD_PROG: if (q.index < PROGRAM_DEPTH) words[q.index] = q.program_word;
        CMD_FIELD: if (q.index < FIELD_DEPTH) begin
          field_ty[q.index] = q.value_type;
          field_val[q.index] = q.value;
        end
        CMD_EVAL: begin
          r = classify(q.index);
          evals++;
          if (r.matched) hits++;
          if (r.fault != FLT_OK) faults++;
          verdict_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check(res_t got);
      res_t exp_r;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = verdict_q.pop_front();
      if (got.matched !== exp_r.matched)
        $display("%0t: matched exp %0d got %0d", $time, exp_r.matched, got.matched);
      if (got.hit_edge !== exp_r.hit_edge)
        $display("%0t: hit_edge exp %0d got %0d", $time, exp_r.hit_edge,
                 got.hit_edge);
      if (got.next_node !== exp_r.next_node)
        $display("%0t: next_node exp %0d got %0d", $time, exp_r.next_node,
                 got.next_node);
      if (got.fault !== exp_r.fault)
        $display("%0t: fault exp %0d got %0d", $time, exp_r.fault, got.fault);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  localparam int LIMIT = 2000000;
  localparam int PHASE_ITEMS = 85;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycles = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;
  int random_items = 0;
  classifier_scoreboard sb = new();

  dgec_req_if req_ch();
  dgec_res_if res_ch();
  dgec_cfg_if cfg_ch();

  decision_graph_edge_classifier u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) sb.check(res_ch.data);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        res_ch.ready <= (stall_left == 0);
      end
    end
  end

  task automatic send(req_t q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    do @(posedge clk); while (!req_ch.ready);
    sb.note(q);
  endtask

  task automatic set_field_count(logic [6:0] n);
    req_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= n;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.field_count = n;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t mk(logic [2:0] cmd, logic [11:0] idx);
    req_t q;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(req_t)-1:0];
    q.command = cmd;
    q.index = idx;
    return q;
  endfunction

  function automatic req_t mk_atom(logic [11:0] idx, logic [7:0] fld, logic [2:0] op,
                                   logic [1:0] ty, logic [31:0] val);
    req_t q;
    q = mk(CMD_ATOM, idx);
    q.atom_field = fld;
    q.atom_op = op;
    q.value_type = ty;
    q.value = val;
    return q;
  endfunction

  function automatic req_t mk_link(logic [2:0] cmd, logic [11:0] idx, logic [11:0] off,
                                   logic [12:0] cnt, logic [7:0] tgt);
    req_t q;
    q = mk(cmd, idx);
    q.offset = off;
    q.count = cnt;
    q.target = tgt;
    return q;
  endfunction

  function automatic req_t mk_word(logic [11:0] idx, logic [15:0] w);
    req_t q;
    q = mk(CMD_PROG, idx);
    q.program_word = w;
    return q;
  endfunction

  function automatic req_t mk_field(logic [11:0] idx, logic [1:0] ty, logic [31:0] val);
    req_t q;
    q = mk(CMD_FIELD, idx);
    q.value_type = ty;
    q.value = val;
    return q;
  endfunction

  function automatic req_t random_request();
    req_t q;
    int k;
    int p;
    q = mk(3'($urandom_range(0, 7)), 12'($urandom));
    q.count = (q.count[12] && $urandom_range(0, 9) == 0) ? 13'd4096 :
              13'($urandom_range(0, 12));
    if ($urandom_range(0, 99) < 8) begin
      // raw request: links and evaluates land out of range, words never name a live atom
      if (q.command == CMD_NODE || q.command == CMD_EDGE) q.count = 13'($urandom_range(0, 8));
      if (q.command == CMD_NODE || q.command == CMD_EDGE || q.command == CMD_EVAL)
        q.index[11] = 1'b1;
      if (q.program_word < ATOM_DEPTH) q.program_word[8] = 1'b1;
      return q;
    end
    k = $urandom_range(0, 99);
    if (k < 30) begin
      q.command = CMD_EVAL;
      q.index = 12'($urandom_range(0, 7));
    end else if (k < 45) begin
      q.command = CMD_ATOM;
      q.index = 12'($urandom_range(0, 15));
      q.atom_field = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) q.value = $urandom_range(0, 3) - 1;
    end else if (k < 55) begin
      q.command = CMD_FIELD;
      q.index = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 63)) :
                12'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) q.value = $urandom_range(0, 3) - 1;
    end else if (k < 75) begin
      q.command = CMD_PROG;
      q.index = 12'($urandom_range(0, 95));
      p = $urandom_range(0, 99);
      if (p < 60) q.program_word = 16'($urandom_range(0, 15));
      else if (p < 95) q.program_word = OP_NOT + 16'($urandom_range(0, 4));
      else q.program_word = 16'($urandom_range(ATOM_DEPTH, 65535));
    end else if (k < 90) begin
      q.command = CMD_EDGE;
      q.index = 12'($urandom_range(0, 31));
      q.offset = 12'($urandom_range(0, 90));
      q.count = 13'($urandom_range(0, 6));
    end else begin
      q.command = CMD_NODE;
      q.index = 12'($urandom_range(0, 7));
      q.offset = 12'($urandom_range(0, 28));
      q.count = 13'($urandom_range(0, 4));
    end
    return q;
  endfunction

  initial begin
    req_t q;
    logic [6:0] fc_list[6];
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    fc_list = '{7'd0, 7'd64, 7'd1, 7'd8, 7'd63, 7'd3};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_field_count(7'd64);

    // every entry that a later request can reach gets a known value first
    no_idle = 1'b1;
    for (int i = 0; i < FIELD_DEPTH; i++) send(mk_field(12'(i), 2'($urandom), $urandom));
    for (int i = 0; i < 16; i++)
      send(mk_atom(12'(i), 8'($urandom_range(0, 7)), 3'($urandom), 2'($urandom), $urandom));
    for (int i = 0; i < 8; i++) send(mk_link(CMD_NODE, 12'(i), 0, 0, 0));
    for (int i = 0; i < 32; i++) send(mk_link(CMD_EDGE, 12'(i), 0, 0, 0));
    for (int i = EDGE_DEPTH - 4; i < EDGE_DEPTH; i++) send(mk_link(CMD_EDGE, 12'(i), 0, 0, 0));
    for (int i = 0; i < 128; i++) send(mk_word(12'(i), OP_TRUE));
    send(mk_word(12'(PROGRAM_DEPTH - 1), OP_TRUE));
    no_idle = 1'b0;

    send(mk_field(0, TY_INT, 5));
    send(mk_field(1, TY_STR, 7));
    send(mk_field(63, TY_INT, 32'h8000_0000));
    send(mk_field(12'hFFF, TY_BOOL, 1));
    send(mk_atom(0, 0, AOP_EQ, TY_INT, 5));
    send(mk_atom(1, 1, AOP_NE, TY_STR, 7));
    send(mk_atom(2, 63, AOP_LT, TY_INT, 32'h7FFF_FFFF));
    send(mk_atom(3, 8'hFF, AOP_TRUTHY, TY_NONE, 0));
    send(mk_atom(12'hFFF, 0, 3'd7, TY_INT, 0));
    send(mk_word(0, 16'd0));
    send(mk_word(1, 16'd1));
    send(mk_word(3, OP_NOT));
    send(mk_word(5, 16'hFFFF));
    send(mk_word(6, 16'h7FFF));
    send(mk_word(7, OP_FALSE));
    send(mk_link(CMD_EDGE, 0, 0, 2, 8'hFF));
    send(mk_link(CMD_EDGE, 1, 3, 1, 8'h11));
    send(mk_link(CMD_EDGE, 2, 7, 1, 8'h22));
    send(mk_link(CMD_EDGE, 3, 5, 1, 8'h33));
    send(mk_link(CMD_EDGE, 4, 6, 1, 8'h44));
    send(mk_link(CMD_EDGE, 5, 100, 17, 8'h55));
    send(mk_link(CMD_EDGE, 6, 12'hFFF, 13'd4096, 8'hAA));
    send(mk_link(CMD_NODE, 0, 2, 3, 0));
    send(mk_link(CMD_NODE, 1, 0, 1, 0));
    send(mk_link(CMD_NODE, 2, 1, 1, 0));
    send(mk_link(CMD_NODE, 3, 1020, 13'd4096, 0));
    send(mk_link(CMD_NODE, 4, 5, 2, 0));
    send(mk_link(CMD_NODE, 255, 2, 2, 0));
    for (int n = 0; n < 5; n++) send(mk(CMD_EVAL, 12'(n)));
    send(mk(CMD_EVAL, 255));
    send(mk(CMD_EVAL, 12'hFFF));
    send(mk(3'd6, 0));
    send(mk(3'd7, 1));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_field_count(ph == 5 ? 7'($urandom_range(0, 64)) : fc_list[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; ) begin
        q = random_request();
        send(q);
        if (q.command <= CMD_EVAL) n++;
      end
      drain();
    end
    random_items = 6 * PHASE_ITEMS;

    $display("Ran %0d evaluate requests (%0d matched, %0d faulted) and %0d random requests",
             sb.evals, sb.hits, sb.faults, random_items);
    $display("over six field_count settings including 0 and 64");
    if (sb.errors == 0 && sb.verdict_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// File: decision_graph_edge_classifier.f
rtl/dgec_pkg.sv
rtl/dgec_if.sv
rtl/decision_graph_edge_classifier.sv
test/decision_graph_edge_classifier_test.sv
